/* rtl/bisrf_pkg.sv */
// ----------------------------------------------------------------------------
// bisrf_pkg
// Shared constants, codes and controller/datapath interface types of the
// bisection root finder.
// ----------------------------------------------------------------------------
package bisrf_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // tolerance register, unsigned Q15.16
  localparam int                  TOL_WIDTH = 31;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 31'd66;

  // sign of a function value
  typedef logic [1:0] sgn_t;
  localparam sgn_t SGN_ZERO = 2'b00;
  localparam sgn_t SGN_POS  = 2'b01;
  localparam sgn_t SGN_NEG  = 2'b10;

  // source of the evaluation point register
  typedef enum logic [1:0] {
    XSEL_HOLD,
    XSEL_IN,
    XSEL_B,
    XSEL_MID
  } xsel_t;

  // second operand of the shared multiplier
  typedef enum logic [1:0] {
    MSEL_SQ,
    MSEL_LO,
    MSEL_HI
  } msel_t;

  typedef struct packed {
    logic  load_req;       // capture a new request
    xsel_t xsel;
    logic  mul_en;
    msel_t msel;
    logic  sign_from_mul;  // take the sign from the product instead of the range test
    logic  store_sa;
    logic  store_sb;
    logic  upd_interval;   // replace one end by the evaluation point
    logic  out_load;
    logic  out_err;
  } cmd_t;

  typedef struct packed {
    logic class_trivial;   // sign known without the multiplier
    sgn_t cur_sign;
    logic no_change;       // end signs not strictly opposite
    logic loop_go;         // half width still above tolerance
  } stat_t;

endpackage

/* rtl/bisrf_ctrl.sv */
// ----------------------------------------------------------------------------
// bisrf_ctrl
// Sequencer of the bisection root finder: steps the datapath through the end
// evaluations, the halvings and the result hand-off.
// ----------------------------------------------------------------------------
module bisrf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output bisrf_pkg::cmd_t   cmd,
  input  bisrf_pkg::stat_t  st
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CLASS  = 8'b0000_0010,
    S_MLO    = 8'b0000_0100,
    S_MHI    = 8'b0000_1000,
    S_MFIN   = 8'b0001_0000,
    S_CHECK  = 8'b0010_0000,
    S_LOOP   = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    TGT_A,
    TGT_B,
    TGT_M
  } tgt_t;

  state_t state_r, state_nxt;
  tgt_t   tgt_r, tgt_nxt;
  logic   err_r, err_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   eval_done;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    tgt_nxt       = tgt_r;
    err_nxt       = err_r;
    eval_done     = 1'b0;
    out_valid_nxt = out_valid_r & ~out_tready;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          cmd.xsel     = bisrf_pkg::XSEL_IN;
          tgt_nxt      = TGT_A;
          state_nxt    = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd.mul_en = 1'b1;
        cmd.msel   = bisrf_pkg::MSEL_SQ;
        if (st.class_trivial) begin
          eval_done = 1'b1;
        end else begin
          state_nxt = S_MLO;
        end
      end
      S_MLO: begin
        cmd.mul_en = 1'b1;
        cmd.msel   = bisrf_pkg::MSEL_LO;
        state_nxt  = S_MHI;
      end
      S_MHI: begin
        cmd.mul_en = 1'b1;
        cmd.msel   = bisrf_pkg::MSEL_HI;
        state_nxt  = S_MFIN;
      end
      S_MFIN: begin
        cmd.sign_from_mul = 1'b1;
        eval_done         = 1'b1;
      end
      S_CHECK: begin
        if (st.no_change) begin
          err_nxt   = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        cmd.xsel = bisrf_pkg::XSEL_MID;
        if (st.loop_go) begin
          tgt_nxt   = TGT_M;
          state_nxt = S_CLASS;
        end else begin
          err_nxt   = 1'b0;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          cmd.out_err   = err_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (eval_done) begin
      case (tgt_r)
        TGT_A: begin
          cmd.store_sa = 1'b1;
          cmd.xsel     = bisrf_pkg::XSEL_B;
          tgt_nxt      = TGT_B;
          state_nxt    = S_CLASS;
        end
        TGT_B: begin
          cmd.store_sb = 1'b1;
          state_nxt    = S_CHECK;
        end
        TGT_M: begin
          if (st.cur_sign == bisrf_pkg::SGN_ZERO) begin
            err_nxt   = 1'b0;
            state_nxt = S_FINISH;
          end else begin
            cmd.upd_interval = 1'b1;
            state_nxt        = S_LOOP;
          end
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tgt_r       <= TGT_A;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tgt_r       <= tgt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

/* rtl/bisrf_dp.sv */
// ----------------------------------------------------------------------------
// bisrf_dp
// Datapath of the bisection root finder: interval registers, midpoint and
// width logic, sign tests and the shared multiplier for the cubic.
// ----------------------------------------------------------------------------
module bisrf_dp #(
  parameter int DATA_WIDTH = bisrf_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = bisrf_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bisrf_pkg::cmd_t                 cmd,
  output bisrf_pkg::stat_t                st,
  input  logic                            in_func,
  input  logic [DATA_WIDTH-1:0]           in_left,
  input  logic [DATA_WIDTH-1:0]           in_right,
  input  logic                            cfg_wr_en,
  input  logic [bisrf_pkg::TOL_WIDTH-1:0] cfg_wr_data,
  output logic [DATA_WIDTH-1:0]           root,
  output logic                            status
);

  localparam int W   = DATA_WIDTH;
  localparam int TLW = bisrf_pkg::TOL_WIDTH;
  localparam int XW  = W + 2;              // sign-extended point for range tests
  localparam int MW  = FRAC_BITS + 2;      // multiplier operand width
  localparam int TW  = 2 * FRAC_BITS + 3;  // x^2 + 2 in fixed point
  localparam int HW  = TW - MW;            // upper slice of that sum
  localparam int PW  = 3 * FRAC_BITS + 4;  // x^3 + 2x scaled

  localparam logic signed [XW-1:0] ONE_X     = XW'(1) << FRAC_BITS;
  localparam logic signed [XW-1:0] TWO_X     = XW'(2) << FRAC_BITS;
  localparam logic signed [XW-1:0] NEG_ONE_X = -ONE_X;
  localparam logic [TW-1:0]        T_ADD     = TW'(2) << (2 * FRAC_BITS);
  localparam logic [PW-1:0]        K_FOUR    = PW'(1) << (3 * FRAC_BITS + 2);

  logic                  sel_r;
  logic [W-1:0]          a_r, b_r, x_r;
  logic [2*MW-1:0]       prod_r, acc_r;
  logic [HW-1:0]         thi_r;
  bisrf_pkg::sgn_t       sa_r, sb_r;
  logic [TLW-1:0]        tol_r;
  logic [W-1:0]          root_r;
  logic                  status_r;

  logic [W:0]            sum, diff;
  logic [W-1:0]          mid;
  logic signed [XW-1:0]  xs;
  logic [MW-1:0]         xu, opb;
  logic [TW-1:0]         t;
  logic [2*MW-1:0]       prod;
  logic [PW-1:0]         total;
  bisrf_pkg::sgn_t       class_sign, fin_sign;
  logic                  cubic_trivial;

  // midpoint floor((a+b)/2) and width b-a, one bit wider than the ends
  assign sum  = {a_r[W-1], a_r} + {b_r[W-1], b_r};
  assign diff = {b_r[W-1], b_r} - {a_r[W-1], a_r};
  assign mid  = sum[W:1];

  // range tests; the cubic is monotonic, f(1) < 0 and f(2) > 0
  assign xs = {{2{x_r[W-1]}}, x_r};

  always_comb begin
    cubic_trivial = 1'b1;
    if (sel_r) begin
      if (xs > ONE_X || xs < NEG_ONE_X) begin
        class_sign = bisrf_pkg::SGN_POS;
      end else if (xs == ONE_X || xs == NEG_ONE_X) begin
        class_sign = bisrf_pkg::SGN_ZERO;
      end else begin
        class_sign = bisrf_pkg::SGN_NEG;
      end
    end else begin
      if (xs <= ONE_X) begin
        class_sign = bisrf_pkg::SGN_NEG;
      end else if (xs >= TWO_X) begin
        class_sign = bisrf_pkg::SGN_POS;
      end else begin
        class_sign    = bisrf_pkg::SGN_NEG;
        cubic_trivial = 1'b0;
      end
    end
  end

  // x * (x^2 + 2) against 4, x in (1, 2): square, then low and high slices
  assign xu = x_r[MW-1:0];
  assign t  = prod_r[TW-1:0] + T_ADD;

  always_comb begin
    case (cmd.msel)
      bisrf_pkg::MSEL_SQ: opb = xu;
      bisrf_pkg::MSEL_LO: opb = t[MW-1:0];
      bisrf_pkg::MSEL_HI: opb = MW'(thi_r);
      default:            opb = xu;
    endcase
  end

  assign prod  = {{MW{1'b0}}, xu} * {{MW{1'b0}}, opb};
  assign total = PW'(acc_r) + (PW'(prod_r) << MW);

  always_comb begin
    if (total > K_FOUR) begin
      fin_sign = bisrf_pkg::SGN_POS;
    end else if (total == K_FOUR) begin
      fin_sign = bisrf_pkg::SGN_ZERO;
    end else begin
      fin_sign = bisrf_pkg::SGN_NEG;
    end
  end

  assign st.class_trivial = sel_r | cubic_trivial;
  assign st.cur_sign      = cmd.sign_from_mul ? fin_sign : class_sign;
  assign st.no_change     = (sa_r == bisrf_pkg::SGN_ZERO) || (sb_r == bisrf_pkg::SGN_ZERO) ||
                            (sa_r == sb_r);
  assign st.loop_go       = !diff[W] &&
                            ({{TLW{1'b0}}, diff[W:1]} > {{W{1'b0}}, tol_r});

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      sel_r <= in_func;
      a_r   <= in_left;
      b_r   <= in_right;
    end else if (cmd.upd_interval) begin
      // keep the half that holds the sign change
      if (st.cur_sign != sa_r) begin
        b_r <= x_r;
      end else begin
        a_r <= x_r;
      end
    end

    case (cmd.xsel)
      bisrf_pkg::XSEL_IN:  x_r <= in_left;
      bisrf_pkg::XSEL_B:   x_r <= b_r;
      bisrf_pkg::XSEL_MID: x_r <= mid;
      default:             x_r <= x_r;
    endcase

    if (cmd.mul_en) begin
      prod_r <= prod;
      if (cmd.msel == bisrf_pkg::MSEL_LO) begin
        thi_r <= t[TW-1:MW];
      end
      if (cmd.msel == bisrf_pkg::MSEL_HI) begin
        acc_r <= prod_r;
      end
    end

    if (cmd.store_sa) begin
      sa_r <= st.cur_sign;
    end
    if (cmd.store_sb) begin
      sb_r <= st.cur_sign;
    end

    if (cmd.out_load) begin
      root_r   <= cmd.out_err ? '0 : x_r;
      status_r <= cmd.out_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= bisrf_pkg::TOL_RESET;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  assign root   = root_r;
  assign status = status_r;

endmodule

/* rtl/bisection_root_finder.sv */
// Sequence: accept, evaluate both end points (the cubic needs the multiplier
// for points in (1, 2)), check the end signs, halve until the half width is
// within the tolerance or the midpoint is a root, then load the result register.
// Throughput: one request at a time, set by the halving loop on the shared multiplier.
// Reset (rst_n low, synchronous): sequencer idle, no result pending,
// tolerance back to 66 (about 0.001).
// ----------------------------------------------------------------------------
// bisection_root_finder
// Fixed-point bisection solver for x^3+2x-4 and x^2-1 on a given interval,
// built from a sequencer and a datapath with one shared multiplier.
// ----------------------------------------------------------------------------
module bisection_root_finder #(
  parameter int DATA_WIDTH = bisrf_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = bisrf_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // request channel
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // left_bound, right_bound (signed, from bit 0 up), zero padded to bytes
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]     in_tdata,
  // func: 0 selects x^3+2x-4, 1 selects x^2-1
  input  logic                                  in_tuser,
  // result channel
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // root (signed), zero padded to bytes
  output logic [((DATA_WIDTH+7)/8)*8-1:0]       out_tdata,
  // status: 0 root found, 1 no sign change at the ends
  output logic                                  out_tuser,
  // tolerance register
  input  logic                                  cfg_wr_en,
  input  logic [bisrf_pkg::TOL_WIDTH-1:0]       cfg_wr_data
);

  localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8;

  bisrf_pkg::cmd_t        cmd;
  bisrf_pkg::stat_t       st;
  logic [DATA_WIDTH-1:0]  left_bound;
  logic [DATA_WIDTH-1:0]  right_bound;
  logic [DATA_WIDTH-1:0]  root;
  logic                   status;

  // unpack the request; padding bits above the two bounds are ignored
  assign left_bound  = in_tdata[DATA_WIDTH-1:0];
  assign right_bound = in_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

  // Sequencer: walks the end evaluations, sign check and halving loop.
  bisrf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .st         (st)
  );

  // Datapath: interval, midpoint, sign tests, shared multiplier, result
  // register. The result register frees the input side while a result waits.
  bisrf_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .in_func     (in_tuser),
    .in_left     (left_bound),
    .in_right    (right_bound),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .root        (root),
    .status      (status)
  );

  // zero-extend the root into the byte-wide data bus
  assign out_tdata = OUT_W'(root);
  assign out_tuser = status;

endmodule

/* rtl/bisrf_checker.sv */
// ----------------------------------------------------------------------------
// bisrf_checker
// Port-level checks of the bisection root finder, bound to the top level.
// ----------------------------------------------------------------------------
module bisrf_checker #(
  parameter int DATA_WIDTH = bisrf_pkg::DATA_WIDTH_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [((DATA_WIDTH+7)/8)*8-1:0]   out_tdata,
  input logic                              out_tuser
);

  // an error result always carries a zero root
  a_err_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("error result with nonzero root");

  // one request in flight: drop ready right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

  // a new result appears only as the sequencer returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result raised while busy");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind bisection_root_finder bisrf_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_bisrf_checker (.*);
